### rtl/core/tchfp_pkg.sv
// shared types and constants for the client hello fingerprint parser
package tchfp_pkg;

	localparam int MAX_CURVES = 32;
	localparam int MAX_POINTS = 8;
	localparam int CRV_AW = $clog2(MAX_CURVES);
	localparam int PT_AW = $clog2(MAX_POINTS);
	localparam int CRV_CW = $clog2(MAX_CURVES + 1);
	localparam int PT_CW = $clog2(MAX_POINTS + 1);

	localparam logic [7:0] REC_HANDSHAKE = 8'd22;
	localparam logic [7:0] HS_CLIENT_HELLO = 8'd1;
	localparam logic [15:0] EXT_CURVES = 16'd10;
	localparam logic [15:0] EXT_POINTS = 16'd11;
	localparam logic [15:0] TLS_VER_12 = 16'h0303;

	localparam logic [2:0] SEC_VERSION = 3'd0;
	localparam logic [2:0] SEC_CIPHER = 3'd1;
	localparam logic [2:0] SEC_EXT = 3'd2;
	localparam logic [2:0] SEC_CURVE = 3'd3;
	localparam logic [2:0] SEC_POINT = 3'd4;
	localparam logic [2:0] SEC_END = 3'd5;

	localparam logic [15:0] ST_OK = 16'd0;
	localparam logic [15:0] ST_OVERFLOW = 16'd1;
	localparam logic [15:0] ST_TRUNC = 16'd2;
	localparam logic [15:0] ST_NOT_CH = 16'd3;

	typedef enum logic [4:0] {
		PH_REC_TYPE, PH_REC_SKIP, PH_HS_TYPE, PH_HS_LEN, PH_VER_HI, PH_VER_LO,
		PH_RANDOM, PH_SID_LEN, PH_SID_SKIP, PH_CLEN_HI, PH_CLEN_LO, PH_CIPH_HI,
		PH_CIPH_LO, PH_COMP_LEN, PH_COMP_SKIP, PH_XLEN_HI, PH_XLEN_LO,
		PH_XTYPE_HI, PH_XTYPE_LO, PH_XBLEN_HI, PH_XBLEN_LO, PH_XBODY,
		PH_CRVLEN_HI, PH_CRVLEN_LO, PH_CRV_HI, PH_CRV_LO, PH_PTLEN, PH_PT,
		PH_DONE, PH_REJECT
	} phase_t;

	typedef enum logic [4:0] {
		CS_PARSE = 5'b00001,
		CS_CRV = 5'b00010,
		CS_PT = 5'b00100,
		CS_END = 5'b01000,
		CS_WAIT = 5'b10000
	} ctl_state_t;

	// controller to datapath
	typedef struct packed {
		logic parse_en;
		logic flush_start;
		logic crv_rd;
		logic pt_rd;
		logic clear;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tok;
		logic [2:0] tok_sec;
		logic [15:0] tok_code;
		logic [CRV_CW-1:0] crv_count;
		logic [PT_CW-1:0] pt_count;
		logic [CRV_CW-1:0] crv_idx;
		logic [PT_CW-1:0] pt_idx;
		logic [15:0] crv_data;
		logic [7:0] pt_data;
		logic [15:0] status;
	} dp_stat_t;

endpackage

### rtl/core/tchfp_ram.sv
// generic ram, one write and one read port, with registered read
module tchfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/tchfp_datapath.sv
// byte parser datapath: phase, counters, curve and point stores
module tchfp_datapath (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input tchfp_pkg::dp_cmd_t cmd,
	output tchfp_pkg::dp_stat_t stat
);
	tchfp_pkg::phase_t phase_q, ph_n;
	logic [15:0] field_q, field_n, list_q, list_n, ext_q, ext_n, xtype_q, xtype_n;
	logic [15:0] word_q, word_n, status_q;
	logic [tchfp_pkg::CRV_CW-1:0] crv_cnt_q, crv_idx_q;
	logic [tchfp_pkg::PT_CW-1:0] pt_cnt_q, pt_idx_q;
	logic ovf_q, ovf_n;
	logic tok;
	logic [2:0] tsec;
	logic [15:0] tcode, wb;
	logic in_ext, in_body, crv_we, pt_we, crv_full, pt_full;
	logic [15:0] crv_rdata;
	logic [7:0] pt_rdata;

	assign wb = {word_q[15:8], data_byte};
	assign crv_full = (crv_cnt_q == tchfp_pkg::CRV_CW'(tchfp_pkg::MAX_CURVES));
	assign pt_full = (pt_cnt_q == tchfp_pkg::PT_CW'(tchfp_pkg::MAX_POINTS));

	always_comb begin
		ph_n = phase_q;
		field_n = field_q;
		list_n = list_q;
		ext_n = ext_q;
		xtype_n = xtype_q;
		word_n = word_q;
		ovf_n = ovf_q;
		tok = 1'b0;
		tsec = tchfp_pkg::SEC_VERSION;
		tcode = wb;
		crv_we = 1'b0;
		pt_we = 1'b0;
		in_ext = (phase_q >= tchfp_pkg::PH_XTYPE_HI) && (phase_q <= tchfp_pkg::PH_PT);
		in_body = (phase_q >= tchfp_pkg::PH_XBODY) && (phase_q <= tchfp_pkg::PH_PT);
		if (in_body) begin
			field_n = field_q - 16'd1;
		end
		unique case (phase_q)
			tchfp_pkg::PH_REC_TYPE: begin
				if (data_byte == tchfp_pkg::REC_HANDSHAKE) begin
					ph_n = tchfp_pkg::PH_REC_SKIP;
					field_n = 16'd4;
				end else begin
					ph_n = tchfp_pkg::PH_REJECT;
				end
			end
			tchfp_pkg::PH_REC_SKIP: begin
				field_n = field_q - 16'd1;
				if (field_n == 16'd0) ph_n = tchfp_pkg::PH_HS_TYPE;
			end
			tchfp_pkg::PH_HS_TYPE: begin
				if (data_byte == tchfp_pkg::HS_CLIENT_HELLO) begin
					ph_n = tchfp_pkg::PH_HS_LEN;
					field_n = 16'd3;
				end else begin
					ph_n = tchfp_pkg::PH_REJECT;
				end
			end
			tchfp_pkg::PH_HS_LEN: begin
				field_n = field_q - 16'd1;
				if (field_n == 16'd0) ph_n = tchfp_pkg::PH_VER_HI;
			end
			tchfp_pkg::PH_VER_HI: begin
				word_n = {data_byte, 8'd0};
				ph_n = tchfp_pkg::PH_VER_LO;
			end
			tchfp_pkg::PH_VER_LO: begin
				tok = 1'b1;
				tsec = tchfp_pkg::SEC_VERSION;
				field_n = 16'd32;
				ph_n = tchfp_pkg::PH_RANDOM;
			end
			tchfp_pkg::PH_RANDOM: begin
				field_n = field_q - 16'd1;
				if (field_n == 16'd0) ph_n = tchfp_pkg::PH_SID_LEN;
			end
			tchfp_pkg::PH_SID_LEN: begin
				field_n = {8'd0, data_byte};
				ph_n = (data_byte != 8'd0) ? tchfp_pkg::PH_SID_SKIP : tchfp_pkg::PH_CLEN_HI;
			end
			tchfp_pkg::PH_SID_SKIP: begin
				field_n = field_q - 16'd1;
				if (field_n == 16'd0) ph_n = tchfp_pkg::PH_CLEN_HI;
			end
			tchfp_pkg::PH_CLEN_HI: begin
				word_n = {data_byte, 8'd0};
				ph_n = tchfp_pkg::PH_CLEN_LO;
			end
			tchfp_pkg::PH_CLEN_LO: begin
				list_n = wb;
				ph_n = (wb != 16'd0) ? tchfp_pkg::PH_CIPH_HI : tchfp_pkg::PH_COMP_LEN;
			end
			tchfp_pkg::PH_CIPH_HI: begin
				list_n = list_q - 16'd1;
				if (list_n == 16'd0) begin
					ph_n = tchfp_pkg::PH_COMP_LEN;
				end else begin
					word_n = {data_byte, 8'd0};
					ph_n = tchfp_pkg::PH_CIPH_LO;
				end
			end
			tchfp_pkg::PH_CIPH_LO: begin
				list_n = list_q - 16'd1;
				tok = 1'b1;
				tsec = tchfp_pkg::SEC_CIPHER;
				ph_n = (list_n != 16'd0) ? tchfp_pkg::PH_CIPH_HI : tchfp_pkg::PH_COMP_LEN;
			end
			tchfp_pkg::PH_COMP_LEN: begin
				field_n = {8'd0, data_byte};
				ph_n = (data_byte != 8'd0) ? tchfp_pkg::PH_COMP_SKIP : tchfp_pkg::PH_XLEN_HI;
			end
			tchfp_pkg::PH_COMP_SKIP: begin
				field_n = field_q - 16'd1;
				if (field_n == 16'd0) ph_n = tchfp_pkg::PH_XLEN_HI;
			end
			tchfp_pkg::PH_XLEN_HI, tchfp_pkg::PH_XTYPE_HI, tchfp_pkg::PH_XBLEN_HI,
			tchfp_pkg::PH_CRVLEN_HI: begin
				word_n = {data_byte, 8'd0};
				ph_n = tchfp_pkg::phase_t'(phase_q + 5'd1);
			end
			tchfp_pkg::PH_XLEN_LO: begin
				ext_n = wb;
				ph_n = (wb != 16'd0) ? tchfp_pkg::PH_XTYPE_HI : tchfp_pkg::PH_DONE;
			end
			tchfp_pkg::PH_XTYPE_LO: begin
				xtype_n = wb;
				tok = 1'b1;
				tsec = tchfp_pkg::SEC_EXT;
				ph_n = tchfp_pkg::PH_XBLEN_HI;
			end
			tchfp_pkg::PH_XBLEN_LO: begin
				field_n = wb;
				if (wb == 16'd0) ph_n = tchfp_pkg::PH_XTYPE_HI;
				else if (xtype_q == tchfp_pkg::EXT_CURVES) ph_n = tchfp_pkg::PH_CRVLEN_HI;
				else if (xtype_q == tchfp_pkg::EXT_POINTS) ph_n = tchfp_pkg::PH_PTLEN;
				else ph_n = tchfp_pkg::PH_XBODY;
			end
			tchfp_pkg::PH_XBODY, tchfp_pkg::PH_DONE: begin
			end
			tchfp_pkg::PH_CRVLEN_LO: begin
				list_n = wb;
				ph_n = (wb != 16'd0) ? tchfp_pkg::PH_CRV_HI : tchfp_pkg::PH_XBODY;
			end
			tchfp_pkg::PH_CRV_HI: begin
				list_n = list_q - 16'd1;
				if (list_n == 16'd0) begin
					ph_n = tchfp_pkg::PH_XBODY;
				end else begin
					word_n = {data_byte, 8'd0};
					ph_n = tchfp_pkg::PH_CRV_LO;
				end
			end
			tchfp_pkg::PH_CRV_LO: begin
				list_n = list_q - 16'd1;
				if (!crv_full) crv_we = 1'b1;
				else ovf_n = 1'b1;
				ph_n = (list_n != 16'd0) ? tchfp_pkg::PH_CRV_HI : tchfp_pkg::PH_XBODY;
			end
			tchfp_pkg::PH_PTLEN: begin
				list_n = {8'd0, data_byte};
				ph_n = (data_byte != 8'd0) ? tchfp_pkg::PH_PT : tchfp_pkg::PH_XBODY;
			end
			tchfp_pkg::PH_PT: begin
				list_n = list_q - 16'd1;
				if (!pt_full) pt_we = 1'b1;
				else ovf_n = 1'b1;
				ph_n = (list_n != 16'd0) ? tchfp_pkg::PH_PT : tchfp_pkg::PH_XBODY;
			end
			default: ph_n = tchfp_pkg::PH_REJECT;
		endcase
		if (in_body && field_n == 16'd0) ph_n = tchfp_pkg::PH_XTYPE_HI;
		if (in_ext) begin
			ext_n = ext_q - 16'd1;
			if (ext_n == 16'd0) ph_n = tchfp_pkg::PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tchfp_pkg::PH_REC_TYPE;
			field_q <= '0;
			list_q <= '0;
			ext_q <= '0;
			xtype_q <= '0;
			word_q <= '0;
			ovf_q <= 1'b0;
			crv_cnt_q <= '0;
			pt_cnt_q <= '0;
			crv_idx_q <= '0;
			pt_idx_q <= '0;
			status_q <= tchfp_pkg::ST_OK;
		end else if (cmd.clear) begin
			phase_q <= tchfp_pkg::PH_REC_TYPE;
			field_q <= '0;
			list_q <= '0;
			ext_q <= '0;
			xtype_q <= '0;
			word_q <= '0;
			ovf_q <= 1'b0;
			crv_cnt_q <= '0;
			pt_cnt_q <= '0;
		end else begin
			if (cmd.parse_en) begin
				phase_q <= ph_n;
				field_q <= field_n;
				list_q <= list_n;
				ext_q <= ext_n;
				xtype_q <= xtype_n;
				word_q <= word_n;
				ovf_q <= ovf_n;
				if (crv_we) crv_cnt_q <= crv_cnt_q + 1'b1;
				if (pt_we) pt_cnt_q <= pt_cnt_q + 1'b1;
				// final status from the phase after this byte
				if (ph_n == tchfp_pkg::PH_REJECT) status_q <= tchfp_pkg::ST_NOT_CH;
				else if (tok || (ph_n != tchfp_pkg::PH_DONE && ph_n != tchfp_pkg::PH_XLEN_HI))
					status_q <= tchfp_pkg::ST_TRUNC;
				else if (ovf_n) status_q <= tchfp_pkg::ST_OVERFLOW;
				else status_q <= tchfp_pkg::ST_OK;
			end
			if (cmd.flush_start) begin
				crv_idx_q <= '0;
				pt_idx_q <= '0;
			end else begin
				if (cmd.crv_rd) crv_idx_q <= crv_idx_q + 1'b1;
				if (cmd.pt_rd) pt_idx_q <= pt_idx_q + 1'b1;
			end
		end
	end

	// read address runs one ahead so registered data lines up with the index
	logic [tchfp_pkg::CRV_CW-1:0] crv_ra;
	logic [tchfp_pkg::PT_CW-1:0] pt_ra;
	assign crv_ra = cmd.flush_start ? '0 : (cmd.crv_rd ? crv_idx_q + 1'b1 : crv_idx_q);
	assign pt_ra = cmd.flush_start ? '0 : (cmd.pt_rd ? pt_idx_q + 1'b1 : pt_idx_q);

	tchfp_ram #(.WIDTH(16), .DEPTH(tchfp_pkg::MAX_CURVES)) u_crv_ram (
		.clk(clk),
		.we(cmd.parse_en && crv_we),
		.waddr(crv_cnt_q[tchfp_pkg::CRV_AW-1:0]),
		.wdata(wb),
		.raddr(crv_ra[tchfp_pkg::CRV_AW-1:0]),
		.rdata(crv_rdata)
	);

	tchfp_ram #(.WIDTH(8), .DEPTH(tchfp_pkg::MAX_POINTS)) u_pt_ram (
		.clk(clk),
		.we(cmd.parse_en && pt_we),
		.waddr(pt_cnt_q[tchfp_pkg::PT_AW-1:0]),
		.wdata(data_byte),
		.raddr(pt_ra[tchfp_pkg::PT_AW-1:0]),
		.rdata(pt_rdata)
	);

	always_comb begin
		stat.tok = tok;
		stat.tok_sec = tsec;
		stat.tok_code = (phase_q == tchfp_pkg::PH_XTYPE_LO) ? wb : tcode;
		stat.crv_count = crv_cnt_q;
		stat.pt_count = pt_cnt_q;
		stat.crv_idx = crv_idx_q;
		stat.pt_idx = pt_idx_q;
		stat.crv_data = crv_rdata;
		stat.pt_data = pt_rdata;
		stat.status = status_q;
	end
endmodule

### rtl/core/tchfp_ctrl.sv
// controller: intake handshake, output register and end-of-record flush sequence
module tchfp_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic last_byte,
	output logic in_stall,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] section,
	output logic [15:0] code_value,
	output logic last_of_run,
	output tchfp_pkg::dp_cmd_t cmd,
	input tchfp_pkg::dp_stat_t stat
);
	tchfp_pkg::ctl_state_t state_q, state_n;
	logic out_free, accept, load;
	logic [2:0] sec_n;
	logic [15:0] code_n;
	logic fin_n;
	logic crv_more, pt_more;

	assign out_free = !out_valid || !out_stall;
	assign in_stall = (state_q != tchfp_pkg::CS_PARSE) || !out_free;
	assign accept = in_valid && !in_stall;
	assign crv_more = (stat.crv_idx < stat.crv_count);
	assign pt_more = (stat.pt_idx < stat.pt_count);

	always_comb begin
		state_n = state_q;
		load = 1'b0;
		sec_n = stat.tok_sec;
		code_n = stat.tok_code;
		fin_n = 1'b0;
		cmd = '0;
		unique case (state_q)
			tchfp_pkg::CS_PARSE: begin
				if (accept) begin
					cmd.parse_en = 1'b1;
					if (last_byte) begin
						cmd.flush_start = 1'b1;
						state_n = tchfp_pkg::CS_WAIT;
					end else if (stat.tok) begin
						load = 1'b1;
					end
				end
			end
			// wait state for the first registered reads
			tchfp_pkg::CS_WAIT: state_n = tchfp_pkg::CS_CRV;
			tchfp_pkg::CS_CRV: begin
				if (!crv_more) begin
					state_n = tchfp_pkg::CS_PT;
				end else if (out_free) begin
					load = 1'b1;
					sec_n = tchfp_pkg::SEC_CURVE;
					code_n = stat.crv_data;
					cmd.crv_rd = 1'b1;
				end
			end
			tchfp_pkg::CS_PT: begin
				if (!pt_more) begin
					state_n = tchfp_pkg::CS_END;
				end else if (out_free) begin
					load = 1'b1;
					sec_n = tchfp_pkg::SEC_POINT;
					code_n = {8'd0, stat.pt_data};
					cmd.pt_rd = 1'b1;
				end
			end
			tchfp_pkg::CS_END: begin
				if (out_free) begin
					load = 1'b1;
					sec_n = tchfp_pkg::SEC_END;
					code_n = stat.status;
					fin_n = 1'b1;
					cmd.clear = 1'b1;
					state_n = tchfp_pkg::CS_PARSE;
				end
			end
			default: state_n = tchfp_pkg::CS_PARSE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tchfp_pkg::CS_PARSE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_n;
			if (load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			section <= sec_n;
			code_value <= code_n;
			last_of_run <= fin_n;
		end
	end
endmodule

### rtl/core/tls_client_hello_fingerprint_parser.sv
// top level of the tls client hello fingerprint token parser
// one byte per cycle while parsing unless the output holds a stalled item;
// a token appears in the cycle after its byte; on the last byte intake stops
// for the flush: a wait state, the curves, the points, then the end token
// asynchronous active-low reset returns the parser to the record header phase
// with empty curve and point buffers and no item on the output
module tls_client_hello_fingerprint_parser (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [7:0] data_byte,
	input logic last_byte,
	output logic out_valid,
	input logic out_stall,
	output logic [2:0] section,
	output logic [15:0] code_value,
	output logic last_of_run
);
	tchfp_pkg::dp_cmd_t cmd;
	tchfp_pkg::dp_stat_t stat;

	tchfp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.last_byte(last_byte),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.section(section),
		.code_value(code_value),
		.last_of_run(last_of_run),
		.cmd(cmd),
		.stat(stat)
	);

	tchfp_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.cmd(cmd),
		.stat(stat)
	);
endmodule

### rtl/core/tchfp_checker.sv
// port-level checks for the fingerprint parser, bound to the top level
module tchfp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] section,
	input logic [15:0] code_value,
	input logic last_of_run
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_value) && $stable(section))
		else $error("stalled output item changed");

	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (section == tchfp_pkg::SEC_END)))
		else $error("end flag does not match end section");

	a_end_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_of_run |-> code_value <= tchfp_pkg::ST_NOT_CH)
		else $error("end status out of range");

	a_no_intake_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("input taken while output blocked");
endmodule

bind tls_client_hello_fingerprint_parser tchfp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .section(section),
	.code_value(code_value), .last_of_run(last_of_run)
);

### tb/tchfp_checker.sv
// checker for the client hello fingerprint parser: token prediction and comparison
`timescale 1ns / 100ps
module tchfp_scoreboard
	import tchfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic out_valid,
	input logic out_stall,
	input logic [2:0] section,
	input logic [15:0] code_value,
	input logic last_of_run,
	output int fail_count,
	output int pending_tokens,
	output int records_done
);

	typedef struct packed {
		logic [2:0] sec;
		logic [15:0] code;
		logic fin;
	} token_t;

	token_t token_q[$];

	phase_t phase;
	logic [15:0] fld_rem, lst_rem, ext_rem, ext_type, word;
	logic [15:0] curves[MAX_CURVES];
	logic [7:0] points[MAX_POINTS];
	int n_curves, n_points;
	logic ovf;

	function automatic void clear_parse();
		phase = PH_REC_TYPE;
		fld_rem = '0;
		lst_rem = '0;
		ext_rem = '0;
		ext_type = '0;
		word = '0;
		n_curves = 0;
		n_points = 0;
		ovf = 1'b0;
	endfunction

	function automatic void push_token(logic [2:0] s, logic [15:0] c, logic f);
		token_t t;
		t.sec = s;
		t.code = c;
		t.fin = f;
		token_q = {token_q, t};
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic lastb);
		phase_t ph;
		logic in_ext, in_body, tok, dropped;
		logic [2:0] tsec;
		logic [15:0] tcode, st;
		ph = phase;
		in_ext = ph >= PH_XTYPE_HI && ph <= PH_PT;
		in_body = ph >= PH_XBODY && ph <= PH_PT;
		tok = 1'b0;
		dropped = 1'b0;
		tsec = '0;
		tcode = '0;
		if (in_body)
			fld_rem = fld_rem - 16'd1;
		case (ph)
			PH_REC_TYPE: begin
				if (b == REC_HANDSHAKE) begin
					phase = PH_REC_SKIP;
					fld_rem = 16'd4;
				end else
					phase = PH_REJECT;
			end
			PH_REC_SKIP: begin
				fld_rem = fld_rem - 16'd1;
				if (fld_rem == 0) phase = PH_HS_TYPE;
			end
			PH_HS_TYPE: begin
				if (b == HS_CLIENT_HELLO) begin
					phase = PH_HS_LEN;
					fld_rem = 16'd3;
				end else
					phase = PH_REJECT;
			end
			PH_HS_LEN: begin
				fld_rem = fld_rem - 16'd1;
				if (fld_rem == 0) phase = PH_VER_HI;
			end
			PH_VER_HI: begin
				word = {b, 8'h00};
				phase = PH_VER_LO;
			end
			PH_VER_LO: begin
				tok = 1'b1;
				tsec = SEC_VERSION;
				tcode = {word[15:8], b};
				fld_rem = 16'd32;
				phase = PH_RANDOM;
			end
			PH_RANDOM: begin
				fld_rem = fld_rem - 16'd1;
				if (fld_rem == 0) phase = PH_SID_LEN;
			end
			PH_SID_LEN: begin
				fld_rem = {8'h00, b};
				phase = b != 0 ? PH_SID_SKIP : PH_CLEN_HI;
			end
			PH_SID_SKIP: begin
				fld_rem = fld_rem - 16'd1;
				if (fld_rem == 0) phase = PH_CLEN_HI;
			end
			PH_CLEN_HI: begin
				word = {b, 8'h00};
				phase = PH_CLEN_LO;
			end
			PH_CLEN_LO: begin
				lst_rem = {word[15:8], b};
				phase = lst_rem != 0 ? PH_CIPH_HI : PH_COMP_LEN;
			end
			PH_CIPH_HI: begin
				lst_rem = lst_rem - 16'd1;
				if (lst_rem == 0) phase = PH_COMP_LEN;
				else begin
					word = {b, 8'h00};
					phase = PH_CIPH_LO;
				end
			end
			PH_CIPH_LO: begin
				lst_rem = lst_rem - 16'd1;
				tok = 1'b1;
				tsec = SEC_CIPHER;
				tcode = {word[15:8], b};
				phase = lst_rem != 0 ? PH_CIPH_HI : PH_COMP_LEN;
			end
			PH_COMP_LEN: begin
				fld_rem = {8'h00, b};
				phase = b != 0 ? PH_COMP_SKIP : PH_XLEN_HI;
			end
			PH_COMP_SKIP: begin
				fld_rem = fld_rem - 16'd1;
				if (fld_rem == 0) phase = PH_XLEN_HI;
			end
			PH_XLEN_HI: begin
				word = {b, 8'h00};
				phase = PH_XLEN_LO;
			end
			PH_XLEN_LO: begin
				ext_rem = {word[15:8], b};
				phase = ext_rem != 0 ? PH_XTYPE_HI : PH_DONE;
			end
			PH_XTYPE_HI: begin
				word = {b, 8'h00};
				phase = PH_XTYPE_LO;
			end
			PH_XTYPE_LO: begin
				ext_type = {word[15:8], b};
				tok = 1'b1;
				tsec = SEC_EXT;
				tcode = ext_type;
				phase = PH_XBLEN_HI;
			end
			PH_XBLEN_HI: begin
				word = {b, 8'h00};
				phase = PH_XBLEN_LO;
			end
			PH_XBLEN_LO: begin
				fld_rem = {word[15:8], b};
				if (fld_rem == 0) phase = PH_XTYPE_HI;
				else if (ext_type == EXT_CURVES) phase = PH_CRVLEN_HI;
				else if (ext_type == EXT_POINTS) phase = PH_PTLEN;
				else phase = PH_XBODY;
			end
			PH_XBODY: ;
			PH_CRVLEN_HI: begin
				word = {b, 8'h00};
				phase = PH_CRVLEN_LO;
			end
			PH_CRVLEN_LO: begin
				lst_rem = {word[15:8], b};
				phase = lst_rem != 0 ? PH_CRV_HI : PH_XBODY;
			end
			PH_CRV_HI: begin
				lst_rem = lst_rem - 16'd1;
				if (lst_rem == 0) phase = PH_XBODY;
				else begin
					word = {b, 8'h00};
					phase = PH_CRV_LO;
				end
			end
			PH_CRV_LO: begin
				lst_rem = lst_rem - 16'd1;
				if (n_curves < MAX_CURVES) begin
					curves[n_curves] = {word[15:8], b};
					n_curves++;
				end else
					ovf = 1'b1;
				phase = lst_rem != 0 ? PH_CRV_HI : PH_XBODY;
			end
			PH_PTLEN: begin
				lst_rem = {8'h00, b};
				phase = b != 0 ? PH_PT : PH_XBODY;
			end
			PH_PT: begin
				lst_rem = lst_rem - 16'd1;
				if (n_points < MAX_POINTS) begin
					points[n_points] = b;
					n_points++;
				end else
					ovf = 1'b1;
				phase = lst_rem != 0 ? PH_PT : PH_XBODY;
			end
			PH_DONE: ;
			default: phase = PH_REJECT;
		endcase
		if (in_body && fld_rem == 0)
			phase = PH_XTYPE_HI;
		if (in_ext) begin
			ext_rem = ext_rem - 16'd1;
			if (ext_rem == 0) phase = PH_DONE;
		end
		if (tok) begin
			if (lastb) dropped = 1'b1;
			else push_token(tsec, tcode, 1'b0);
		end
		if (lastb) begin
			for (int i = 0; i < n_curves; i++)
				push_token(SEC_CURVE, curves[i], 1'b0);
			for (int i = 0; i < n_points; i++)
				push_token(SEC_POINT, {8'h00, points[i]}, 1'b0);
			if (phase == PH_REJECT) st = ST_NOT_CH;
			else if (dropped || (phase != PH_DONE && phase != PH_XLEN_HI)) st = ST_TRUNC;
			else if (ovf) st = ST_OVERFLOW;
			else st = ST_OK;
			push_token(SEC_END, st, 1'b1);
			clear_parse();
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		token_t exp_tok;
		int errs;
		if (!arst_n) begin
			clear_parse();
			token_q.delete();
			fail_count <= 0;
			records_done <= 0;
			pending_tokens <= 0;
		end else begin
			errs = 0;
			if (out_valid && !out_stall) begin
				if (token_q.size() == 0) begin
					$error("unexpected token section=%0d code=%0h", section, code_value);
					errs++;
				end else begin
					exp_tok = token_q.pop_front();
					if (section !== exp_tok.sec) begin
						$error("section: expected %0d, got %0d", exp_tok.sec, section);
						errs++;
					end
					if (code_value !== exp_tok.code) begin
						$error("code_value: expected %0h, got %0h", exp_tok.code, code_value);
						errs++;
					end
					if (last_of_run !== exp_tok.fin) begin
						$error("last_of_run: expected %0b, got %0b", exp_tok.fin, last_of_run);
						errs++;
					end
					if (exp_tok.fin) records_done <= records_done + 1;
				end
			end
			if (in_valid && !in_stall)
				predict_byte(data_byte, last_byte);
			fail_count <= fail_count + errs;
			pending_tokens <= token_q.size();
		end
	end

endmodule

### tb/tls_client_hello_fingerprint_parser_tb.sv
// testbench top: record stimulus, clock, reset and verdict for the fingerprint parser
`timescale 1ns / 100ps
module tls_client_hello_fingerprint_parser_tb;
	import tchfp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] data_byte = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] section;
	logic [15:0] code_value;
	logic last_of_run;
	int fail_count, pending_tokens, records_done;
	int bytes_sent = 0;
	logic [7:0] rec[$];
	logic [7:0] ext[$];

	tls_client_hello_fingerprint_parser u_dut (.*);

	tchfp_scoreboard u_chk (.*);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#400000;
		$display("timeout");
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver stall pattern, with calm stretches
	initial begin
		int mode;
		forever begin
			mode = $urandom_range(0, 3);
			repeat ($urandom_range(5, 40)) begin
				@(negedge clk);
				out_stall <= (mode == 0) ? 1'b0 : ($urandom_range(0, 3) < mode);
			end
		end
	end

	int burst_left = 0;

	function automatic void rec_add(logic [7:0] v);
		rec = {rec, v};
	endfunction

	function automatic void ext_add(logic [7:0] v);
		ext = {ext, v};
	endfunction

	task automatic send_byte(logic [7:0] b, logic lastb);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= lastb;
		do @(posedge clk); while (in_stall);
		bytes_sent++;
		@(negedge clk);
	endtask

	// sends the queued record; trunc > 0 cuts it to that length
	task automatic send_record(int trunc);
		int n;
		n = (trunc > 0 && trunc < rec.size()) ? trunc : rec.size();
		for (int i = 0; i < n; i++)
			send_byte(rec[i], i == n - 1);
		rec.delete();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic put16(logic [15:0] v);
		rec_add(v[15:8]);
		rec_add(v[7:0]);
	endtask

	task automatic rand_bytes(int n);
		repeat (n) rec_add(8'($urandom_range(0, 255)));
	endtask

	// client hello with random content, well-formed unless odd or ext_short is set
	task automatic build_hello(int nciph, int ncrv, int npt, logic odd, logic ext_short);
		int sid;
		ext.delete();
		rec_add(REC_HANDSHAKE);
		rand_bytes(4);
		rec_add(HS_CLIENT_HELLO);
		rand_bytes(3);
		put16(($urandom_range(0, 3) == 0) ? 16'($urandom) : TLS_VER_12);
		rand_bytes(32);
		sid = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 8));
		rec_add(8'(sid));
		rand_bytes(sid);
		put16(16'(2 * nciph + int'(odd)));
		rand_bytes(2 * nciph + int'(odd));
		rec_add(8'd1);
		rec_add(8'd0);
		// curves extension
		ext_add(8'd0); ext_add(EXT_CURVES[7:0]);
		ext_add(8'((2 * ncrv + 2) >> 8)); ext_add(8'(2 * ncrv + 2));
		ext_add(8'((2 * ncrv) >> 8)); ext_add(8'(2 * ncrv));
		repeat (2 * ncrv) ext_add(8'($urandom_range(0, 255)));
		// random other extension
		ext_add(8'($urandom_range(0, 255))); ext_add(8'($urandom_range(12, 255)));
		ext_add(8'd0); ext_add(8'd2);
		ext_add(8'($urandom_range(0, 255))); ext_add(8'($urandom_range(0, 255)));
		// points extension
		ext_add(8'd0); ext_add(EXT_POINTS[7:0]);
		ext_add(8'd0); ext_add(8'(npt + 1));
		ext_add(8'(npt));
		repeat (npt) ext_add(8'($urandom_range(0, 255)));
		put16(16'(ext.size() - (ext_short ? 3 : 0)));
		foreach (ext[i]) rec_add(ext[i]);
		if (ext_short) rand_bytes(2);
	endtask

	initial begin
		int kind, budget, cut;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed records
		build_hello(1, 2, 9, 1'b1, 1'b0); send_record(0);
		build_hello(2, 1, 1, 1'b0, 1'b0); send_record(12);
		build_hello(2, 0, 0, 1'b0, 1'b0); send_record(13);
		rec_add(8'hff); rand_bytes(4); send_record(0);
		rec_add(REC_HANDSHAKE); rand_bytes(4); rec_add(8'h02); rand_bytes(5);
		send_record(0);
		rec_add(8'h00); send_record(0);
		rec_add(REC_HANDSHAKE); send_record(0);

		// wait for all tokens so the sender idles across a full drain
		while (pending_tokens != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		// random records, some cut short, each cut as needed so the total stays within 170 bytes
		while (bytes_sent < 160) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				build_hello(int'($urandom_range(0, 6)), int'($urandom_range(0, 6)),
					int'($urandom_range(0, 4)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 4) == 0);
			end else if (kind < 8) begin
				build_hello(int'($urandom_range(0, 4)), int'($urandom_range(0, 4)),
					int'($urandom_range(0, 3)), 1'b0, 1'b0);
			end else begin
				rand_bytes(int'($urandom_range(1, 20)));
			end
			budget = 170 - bytes_sent;
			cut = (kind >= 6 && kind < 8) ? int'($urandom_range(1, rec.size())) : 0;
			if (rec.size() > budget && (cut == 0 || cut > budget))
				cut = budget;
			send_record(cut);
		end

		while (pending_tokens != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("sent %0d bytes in %0d records: well-formed, cut short, rejected, overflowing",
			bytes_sent, records_done);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
